// ----- design/pss_pkg.sv -----
// Shared types and constants of the process state scheduler.
`timescale 1ns / 1ps
package pss_pkg;

    // Sizes
    localparam int MAX_PROCS   = 16;
    localparam int ID_W        = 4;
    localparam int NUM_DEVICES = 4;
    localparam int DEV_W       = 2;
    localparam int TICK_W      = 32;
    localparam int NUM_Q       = 3 + NUM_DEVICES;
    localparam int Q_W         = 3;
    localparam int CNT_W       = 5;
    localparam int QMEM_DEPTH  = NUM_Q * MAX_PROCS;
    localparam int QADDR_W     = Q_W + ID_W;
    localparam int COST_W      = 16;
    localparam int OUT_W       = 82;

    // Queue numbers inside the scheduler
    localparam logic [Q_W-1:0] Q_NEW   = 3'd0;
    localparam logic [Q_W-1:0] Q_READY = 3'd1;
    localparam logic [Q_W-1:0] Q_EXIT  = 3'd2;
    localparam logic [Q_W-1:0] Q_DEV0  = 3'd3;

    // Queue numbers as seen by a query
    localparam logic [3:0] QQ_NEW     = 4'd1;
    localparam logic [3:0] QQ_READY   = 4'd2;
    localparam logic [3:0] QQ_RUNNING = 4'd3;
    localparam logic [3:0] QQ_EXIT    = 4'd5;
    localparam logic [3:0] QQ_DEV0    = 4'd6;
    localparam logic [3:0] QQ_DEV3    = 4'd9;

    // Configuration register indexes
    localparam logic [1:0] REG_IO_TIMEOUT    = 2'd0;
    localparam logic [1:0] REG_ADMIT_COST    = 2'd1;
    localparam logic [1:0] REG_DISPATCH_COST = 2'd2;
    localparam logic [1:0] REG_RELEASE_COST  = 2'd3;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_STEP    = 3'd1,
        OP_WAIT    = 3'd2,
        OP_IO      = 3'd3,
        OP_QUERY   = 3'd4,
        OP_RELEASE = 3'd5
    } op_code_t;

    typedef enum logic [2:0] {
        ST_FREE    = 3'd0,
        ST_NEW     = 3'd1,
        ST_READY   = 3'd2,
        ST_RUN     = 3'd3,
        ST_BLOCK   = 3'd4,
        ST_EXIT    = 3'd5
    } proc_st_t;

    typedef enum logic [2:0] {
        RES_OK        = 3'd0,
        RES_DUP       = 3'd1,
        RES_NONE_RUN  = 3'd2,
        RES_BAD_DEV   = 3'd3,
        RES_DEV_EMPTY = 3'd4,
        RES_NOT_FOUND = 3'd5,
        RES_NO_HOST   = 3'd6
    } res_t;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_CODE,
        DP_ADD,
        DP_READ_HEAD,
        DP_EXIT_FREE,
        DP_NEW_READY,
        DP_DEV_CHECK,
        DP_PREEMPT,
        DP_DISPATCH,
        DP_WAIT,
        DP_IO_MOVE,
        DP_QUERY,
        DP_RELEASE
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EXIT_CHK,
        S_EXIT_DO,
        S_NEW_CHK,
        S_NEW_DO,
        S_DEV_CHK,
        S_DEV_DO,
        S_PREEMPT,
        S_DISP_CHK,
        S_DISP_DO,
        S_IO_RD,
        S_IO_DO,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t          op;
        logic [Q_W-1:0]  q;
        res_t            code;
        logic            load_out;
    } dp_cmd_t;

    typedef struct packed {
        op_code_t          op;
        logic [2:0]        device;
        logic              hosted;
        logic [NUM_Q-1:0]  q_nz;
    } dp_stat_t;

endpackage

// ----- design/pss_ctrl.sv -----
// Controller state machine that sequences each operation of the scheduler.
`timescale 1ns / 1ps
module pss_ctrl
    import pss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t        state_reg, state_next;
    logic [DEV_W-1:0]   dev_idx_reg, dev_idx_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;
    logic [Q_W-1:0]     scan_q;
    logic [Q_W-1:0]     io_q;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign scan_q   = Q_DEV0 + Q_W'(dev_idx_reg);
    assign io_q     = Q_DEV0 + Q_W'(stat.device[DEV_W-1:0]);

    // State, device-index and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            dev_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dev_idx_reg <= dev_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        dev_idx_next = dev_idx_reg;
        cmd.op       = DP_NOP;
        cmd.q        = Q_NEW;
        cmd.code     = RES_OK;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (stat.op)
                    OP_ADD:     cmd.op = DP_ADD;
                    OP_WAIT:    cmd.op = DP_WAIT;
                    OP_QUERY:   cmd.op = DP_QUERY;
                    OP_RELEASE: cmd.op = DP_RELEASE;
                    OP_STEP:
                    begin
                        if (!stat.hosted)
                        begin
                            cmd.op   = DP_CODE;
                            cmd.code = RES_NO_HOST;
                        end
                        else
                        begin
                            state_next = S_EXIT_CHK;
                        end
                    end
                    OP_IO:
                    begin
                        if (stat.device >= 3'(NUM_DEVICES))
                        begin
                            cmd.op   = DP_CODE;
                            cmd.code = RES_BAD_DEV;
                        end
                        else if (!stat.q_nz[io_q])
                        begin
                            cmd.op   = DP_CODE;
                            cmd.code = RES_DEV_EMPTY;
                        end
                        else
                        begin
                            state_next = S_IO_RD;
                        end
                    end
                    default: ;
                endcase
            end
            // Drop every exited process
            S_EXIT_CHK:
            begin
                cmd.q = Q_EXIT;
                if (stat.q_nz[Q_EXIT])
                begin
                    cmd.op     = DP_READ_HEAD;
                    state_next = S_EXIT_DO;
                end
                else
                begin
                    state_next = S_NEW_CHK;
                end
            end
            S_EXIT_DO:
            begin
                cmd.op     = DP_EXIT_FREE;
                cmd.q      = Q_EXIT;
                state_next = S_EXIT_CHK;
            end
            // Admit one new process
            S_NEW_CHK:
            begin
                cmd.q        = Q_NEW;
                dev_idx_next = '0;
                if (stat.q_nz[Q_NEW])
                begin
                    cmd.op     = DP_READ_HEAD;
                    state_next = S_NEW_DO;
                end
                else
                begin
                    state_next = S_DEV_CHK;
                end
            end
            S_NEW_DO:
            begin
                cmd.op     = DP_NEW_READY;
                cmd.q      = Q_NEW;
                state_next = S_DEV_CHK;
            end
            // Visit the head of each device queue in turn
            S_DEV_CHK:
            begin
                cmd.q = scan_q;
                if (stat.q_nz[scan_q])
                begin
                    cmd.op     = DP_READ_HEAD;
                    state_next = S_DEV_DO;
                end
                else if (dev_idx_reg == DEV_W'(NUM_DEVICES - 1))
                begin
                    state_next = S_PREEMPT;
                end
                else
                begin
                    dev_idx_next = dev_idx_reg + 1'b1;
                end
            end
            S_DEV_DO:
            begin
                cmd.op = DP_DEV_CHECK;
                cmd.q  = scan_q;
                if (dev_idx_reg == DEV_W'(NUM_DEVICES - 1))
                begin
                    state_next = S_PREEMPT;
                end
                else
                begin
                    dev_idx_next = dev_idx_reg + 1'b1;
                    state_next   = S_DEV_CHK;
                end
            end
            S_PREEMPT:
            begin
                cmd.op     = DP_PREEMPT;
                state_next = S_DISP_CHK;
            end
            S_DISP_CHK:
            begin
                cmd.q = Q_READY;
                if (stat.q_nz[Q_READY])
                begin
                    cmd.op     = DP_READ_HEAD;
                    state_next = S_DISP_DO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DISP_DO:
            begin
                cmd.op     = DP_DISPATCH;
                cmd.q      = Q_READY;
                state_next = S_DONE;
            end
            // Move a whole device queue to ready
            S_IO_RD:
            begin
                cmd.q = io_q;
                if (stat.q_nz[io_q])
                begin
                    cmd.op     = DP_READ_HEAD;
                    state_next = S_IO_DO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_IO_DO:
            begin
                cmd.op     = DP_IO_MOVE;
                cmd.q      = io_q;
                state_next = S_IO_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // The output transaction stays offered until it is taken
    always_comb
    begin
        if (cmd.load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

// ----- design/pss_datapath.sv -----
// Datapath of the scheduler: process table, queue memory, tick counter and results.
`timescale 1ns / 1ps
module pss_datapath
    import pss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         in_op,
    input  logic [ID_W-1:0]    in_proc_id,
    input  logic [2:0]         in_device,
    input  logic [3:0]         in_query_queue,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [COST_W-1:0]  cfg_data,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    output logic [OUT_W-1:0]   out_data
);

    // Configuration registers
    logic [COST_W-1:0] io_timeout_reg, admit_cost_reg, dispatch_cost_reg, release_cost_reg;

    // Latched input transaction
    op_code_t          op_reg;
    logic [ID_W-1:0]   pid_reg;
    logic [2:0]        dev_reg;
    logic [3:0]        qq_reg;

    // Process table
    proc_st_t          proc_status_reg [MAX_PROCS];
    logic [DEV_W-1:0]  proc_device_reg [MAX_PROCS];
    logic [TICK_W-1:0] proc_since_reg  [MAX_PROCS];

    // Queue storage and pointers
    logic [ID_W-1:0]   qmem [QMEM_DEPTH];
    logic [ID_W-1:0]   rd_data_reg;
    logic [ID_W-1:0]   head_reg [NUM_Q];
    logic [CNT_W-1:0]  cnt_reg  [NUM_Q];

    logic              running_valid_reg, running_valid_next;
    logic [ID_W-1:0]   running_id_reg, running_id_next;
    logic [TICK_W-1:0] tick_reg;
    logic [ID_W:0]     hosted_reg;

    // Results of the current transaction
    res_t              res_status_reg, res_status_next;
    proc_st_t          res_pstate_reg, res_pstate_next;
    logic [DEV_W-1:0]  res_wdev_reg, res_wdev_next;
    logic [TICK_W-1:0] res_since_reg, res_since_next;
    logic              res_dvalid_reg, res_dvalid_next;
    logic [ID_W-1:0]   res_did_reg, res_did_next;
    logic [CNT_W-1:0]  res_moved_reg, res_moved_next;
    logic [OUT_W-1:0]  out_data_reg;

    // Control of this cycle
    logic               rd_en;
    logic [QADDR_W-1:0] rd_addr;
    logic               pop;
    logic               push;
    logic [Q_W-1:0]     push_q;
    logic [ID_W-1:0]    push_id;
    logic [QADDR_W-1:0] push_addr;
    logic               push_room;
    logic               ps_we;
    logic [ID_W-1:0]    ps_addr;
    proc_st_t           ps_wdata;
    logic               pw_we;
    logic [TICK_W-1:0]  tick_inc;
    logic               host_inc, host_dec;
    logic [ID_W-1:0]    since_addr;
    logic [TICK_W-1:0]  since_rd;
    logic               timed_out;
    logic               found;
    proc_st_t           pid_st;
    logic [Q_W-1:0]     wait_q;
    logic [DEV_W-1:0]   qq_dev;

    // Status towards the controller
    always_comb
    begin
        stat.op     = op_reg;
        stat.device = dev_reg;
        stat.hosted = (hosted_reg != '0);
        for (int q = 0; q < NUM_Q; q++)
        begin
            stat.q_nz[q] = (cnt_reg[q] != '0);
        end
    end

    assign rd_addr    = {cmd.q, head_reg[cmd.q]};
    assign push_addr  = {push_q, head_reg[push_q] + cnt_reg[push_q][ID_W-1:0]};
    assign push_room  = (cnt_reg[push_q] != CNT_W'(MAX_PROCS));
    assign since_addr = (cmd.op == DP_QUERY) ? pid_reg : rd_data_reg;
    assign since_rd   = proc_since_reg[since_addr];
    assign timed_out  = ((tick_reg - since_rd) >= TICK_W'(io_timeout_reg));
    assign pid_st     = proc_status_reg[pid_reg];
    assign wait_q     = Q_DEV0 + Q_W'(dev_reg[DEV_W-1:0]);
    assign qq_dev     = qq_reg[DEV_W-1:0] - 2'd2;

    // Whether a query finds the id in the named queue
    always_comb
    begin
        case (qq_reg)
            QQ_NEW:     found = (pid_st == ST_NEW);
            QQ_READY:   found = (pid_st == ST_READY);
            QQ_RUNNING: found = running_valid_reg && (running_id_reg == pid_reg);
            QQ_EXIT:    found = (pid_st == ST_EXIT);
            default:
            begin
                found = (qq_reg >= QQ_DEV0) && (qq_reg <= QQ_DEV3) &&
                        (pid_st == ST_BLOCK) && (proc_device_reg[pid_reg] == qq_dev);
            end
        endcase
    end

    // Decode of the micro-operation
    always_comb
    begin
        rd_en              = 1'b0;
        pop                = 1'b0;
        push               = 1'b0;
        push_q             = Q_READY;
        push_id            = rd_data_reg;
        ps_we              = 1'b0;
        ps_addr            = rd_data_reg;
        ps_wdata           = ST_READY;
        pw_we              = 1'b0;
        tick_inc           = '0;
        host_inc           = 1'b0;
        host_dec           = 1'b0;
        running_valid_next = running_valid_reg;
        running_id_next    = running_id_reg;
        res_status_next    = res_status_reg;
        res_pstate_next    = res_pstate_reg;
        res_wdev_next      = res_wdev_reg;
        res_since_next     = res_since_reg;
        res_dvalid_next    = res_dvalid_reg;
        res_did_next       = res_did_reg;
        res_moved_next     = res_moved_reg;
        unique case (cmd.op)
            DP_NOP: ;
            DP_LATCH:
            begin
                res_status_next = RES_OK;
                res_pstate_next = ST_FREE;
                res_wdev_next   = '0;
                res_since_next  = '0;
                res_dvalid_next = 1'b0;
                res_did_next    = '0;
                res_moved_next  = '0;
            end
            DP_CODE: res_status_next = cmd.code;
            DP_ADD:
            begin
                if (pid_st != ST_FREE)
                begin
                    res_status_next = RES_DUP;
                end
                else
                begin
                    ps_we    = 1'b1;
                    ps_addr  = pid_reg;
                    ps_wdata = ST_NEW;
                    push     = 1'b1;
                    push_q   = Q_NEW;
                    push_id  = pid_reg;
                    tick_inc = TICK_W'(admit_cost_reg);
                    host_inc = 1'b1;
                end
            end
            DP_READ_HEAD: rd_en = 1'b1;
            DP_EXIT_FREE:
            begin
                pop      = 1'b1;
                ps_we    = 1'b1;
                ps_wdata = ST_FREE;
                host_dec = 1'b1;
            end
            DP_NEW_READY:
            begin
                pop   = 1'b1;
                ps_we = 1'b1;
                push  = 1'b1;
            end
            DP_DEV_CHECK:
            begin
                if (timed_out)
                begin
                    pop   = 1'b1;
                    ps_we = 1'b1;
                    push  = 1'b1;
                end
            end
            DP_PREEMPT:
            begin
                if (running_valid_reg)
                begin
                    running_valid_next = 1'b0;
                    ps_we              = 1'b1;
                    ps_addr            = running_id_reg;
                    push               = 1'b1;
                    push_id            = running_id_reg;
                end
            end
            DP_DISPATCH:
            begin
                pop                = 1'b1;
                running_valid_next = 1'b1;
                running_id_next    = rd_data_reg;
                ps_we              = 1'b1;
                ps_wdata           = ST_RUN;
                tick_inc           = TICK_W'(dispatch_cost_reg);
                res_dvalid_next    = 1'b1;
                res_did_next       = rd_data_reg;
            end
            DP_WAIT:
            begin
                if (!running_valid_reg)
                begin
                    res_status_next = RES_NONE_RUN;
                end
                else if (dev_reg >= 3'(NUM_DEVICES))
                begin
                    res_status_next = RES_BAD_DEV;
                    tick_inc        = TICK_W'(1);
                end
                else
                begin
                    running_valid_next = 1'b0;
                    ps_we              = 1'b1;
                    ps_addr            = running_id_reg;
                    ps_wdata           = ST_BLOCK;
                    pw_we              = 1'b1;
                    push               = 1'b1;
                    push_q             = wait_q;
                    push_id            = running_id_reg;
                    tick_inc           = TICK_W'(1);
                end
            end
            DP_IO_MOVE:
            begin
                pop            = 1'b1;
                ps_we          = 1'b1;
                push           = 1'b1;
                tick_inc       = TICK_W'(1);
                res_moved_next = res_moved_reg + 1'b1;
            end
            DP_QUERY:
            begin
                if (!found)
                begin
                    res_status_next = RES_NOT_FOUND;
                end
                else
                begin
                    res_pstate_next = pid_st;
                    if (pid_st == ST_BLOCK)
                    begin
                        res_wdev_next  = proc_device_reg[pid_reg];
                        res_since_next = since_rd;
                    end
                end
            end
            DP_RELEASE:
            begin
                if (!running_valid_reg)
                begin
                    res_status_next = RES_NONE_RUN;
                end
                else
                begin
                    running_valid_next = 1'b0;
                    ps_we              = 1'b1;
                    ps_addr            = running_id_reg;
                    ps_wdata           = ST_EXIT;
                    push               = 1'b1;
                    push_q             = Q_EXIT;
                    push_id            = running_id_reg;
                    tick_inc           = TICK_W'(release_cost_reg);
                end
            end
            default: ;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io_timeout_reg    <= COST_W'(1024);
            admit_cost_reg    <= COST_W'(32);
            dispatch_cost_reg <= COST_W'(256);
            release_cost_reg  <= COST_W'(32);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IO_TIMEOUT:    io_timeout_reg    <= cfg_data;
                REG_ADMIT_COST:    admit_cost_reg    <= cfg_data;
                REG_DISPATCH_COST: dispatch_cost_reg <= cfg_data;
                REG_RELEASE_COST:  release_cost_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control state: process states, queue pointers, running slot, tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                proc_status_reg[i] <= ST_FREE;
            end
            for (int q = 0; q < NUM_Q; q++)
            begin
                head_reg[q] <= '0;
                cnt_reg[q]  <= '0;
            end
            running_valid_reg <= 1'b0;
            running_id_reg    <= '0;
            tick_reg          <= '0;
            hosted_reg        <= '0;
        end
        else
        begin
            if (ps_we)
            begin
                proc_status_reg[ps_addr] <= ps_wdata;
            end
            for (int q = 0; q < NUM_Q; q++)
            begin
                if (pop && (cmd.q == Q_W'(q)))
                begin
                    head_reg[q] <= head_reg[q] + 1'b1;
                    cnt_reg[q]  <= cnt_reg[q] - 1'b1;
                end
                else if (push && push_room && (push_q == Q_W'(q)))
                begin
                    cnt_reg[q] <= cnt_reg[q] + 1'b1;
                end
            end
            running_valid_reg <= running_valid_next;
            running_id_reg    <= running_id_next;
            tick_reg          <= tick_reg + tick_inc;
            if (host_inc)
            begin
                hosted_reg <= hosted_reg + 1'b1;
            end
            else if (host_dec)
            begin
                hosted_reg <= hosted_reg - 1'b1;
            end
        end
    end

    // Wait bookkeeping of blocked processes
    always_ff @(posedge clk)
    begin
        if (pw_we)
        begin
            proc_device_reg[running_id_reg] <= dev_reg[DEV_W-1:0];
            proc_since_reg[running_id_reg]  <= tick_reg;
        end
    end

    // Queue memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (push && push_room)
        begin
            qmem[push_addr] <= push_id;
        end
        if (rd_en)
        begin
            rd_data_reg <= qmem[rd_addr];
        end
    end

    // Latched transaction, results and output register
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LATCH)
        begin
            op_reg  <= op_code_t'(in_op);
            pid_reg <= in_proc_id;
            dev_reg <= in_device;
            qq_reg  <= in_query_queue;
        end
        res_status_reg <= res_status_next;
        res_pstate_reg <= res_pstate_next;
        res_wdev_reg   <= res_wdev_next;
        res_since_reg  <= res_since_next;
        res_dvalid_reg <= res_dvalid_next;
        res_did_reg    <= res_did_next;
        res_moved_reg  <= res_moved_next;
        if (cmd.load_out)
        begin
            out_data_reg <= {tick_reg, res_moved_reg, res_did_reg, res_dvalid_reg,
                             res_since_reg, res_wdev_reg, res_pstate_reg, res_status_reg};
        end
    end

    assign out_data = out_data_reg;

`ifndef SYNTHESIS
    a_hosted_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hosted_reg <= (ID_W + 1)'(MAX_PROCS))
        else $error("more processes hosted than ids exist");

    a_dispatch_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_DISPATCH |=> running_valid_reg)
        else $error("dispatch left the running slot empty");

    a_wait_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_WAIT && running_valid_reg && dev_reg < 3'(NUM_DEVICES))
        |=> !running_valid_reg && proc_status_reg[$past(running_id_reg)] == ST_BLOCK)
        else $error("wait did not block the running process");

    a_io_tick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_IO_MOVE |=> tick_reg == $past(tick_reg) + TICK_W'(1))
        else $error("io event move did not cost one tick");
`endif

endmodule

// ----- design/process_state_scheduler.sv -----
// Top level of the process state scheduler: stream ports, controller and datapath.
// Add, wait, query, release, unknown ops, bad or empty io events and a step with nothing
// hosted pass accept, decode and result; a step also drops each exited process, admits
// one new process, checks each device queue head, preempts and dispatches; an io event
// moves each process of its device queue through one queue-memory read port. One item is
// worked on at a time; the next input transaction is taken in the cycle after the result
// enters the output register. Reset (async, active low): all ids free, all queues empty,
// tick zero, registers at their defaults; no clearing pass, the block is ready at once.
`timescale 1ns / 1ps
module process_state_scheduler
    import pss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // proc_id[3:0], device[6:4], query_queue[10:7], zero
    input  logic [2:0]   s_tuser,   // op[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // status[2:0], proc_state[5:3], wait_device[7:6],
                                    // since_tick[39:8], dispatched_valid[40],
                                    // dispatched_id[44:41], moved_count[49:45],
                                    // tick_now[81:50], zero
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [OUT_W-1:0] out_data;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {6'd0, out_data};

    // Sequencing of each transaction
    pss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Process table, queues and tick counter
    pss_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_op          (s_tuser),
        .in_proc_id     (s_tdata[3:0]),
        .in_device      (s_tdata[6:4]),
        .in_query_queue (s_tdata[10:7]),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .stat           (stat),
        .out_data       (out_data)
    );

endmodule
